>>> hdl/fnmf_pkg.sv
// ----------------------------------------------------------------------------
// fnmf_pkg
// Shared types and constants of the four-neighbor mean filter.
// ----------------------------------------------------------------------------
package fnmf_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = 11;
    localparam int PIX_BITS     = 16;
    localparam int SUM_BITS     = PIX_BITS + 2;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1080);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(1920);
    localparam logic [CFG_BITS-1:0] SIZE_MIN     = CFG_BITS'(3);
    localparam logic [CFG_BITS-1:0] WIDTH_MAX    = CFG_BITS'(MAX_WIDTH);
    localparam logic [CFG_BITS-1:0] HEIGHT_MAX   = CFG_BITS'(2048);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_index;

    typedef logic [PIX_BITS-1:0] t_pix;
    typedef logic [COL_BITS-1:0] t_col;
    typedef logic [ROW_BITS-1:0] t_row;

    // one column of both line buffers
    typedef struct packed {
        t_pix two_back;
        t_pix one_back;
    } t_col_pair;

endpackage

>>> hdl/fnmf_line_buf.sv
// ----------------------------------------------------------------------------
// fnmf_line_buf
// Two line buffers kept as one memory of column pairs, one write and two
// registered reads per cycle.
// ----------------------------------------------------------------------------
module fnmf_line_buf (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  fnmf_pkg::t_col      i_rd_addr_a,
    input  fnmf_pkg::t_col      i_rd_addr_b,
    output fnmf_pkg::t_col_pair o_rd_data_a,
    output fnmf_pkg::t_col_pair o_rd_data_b,
    input  logic                i_wr_en,
    input  fnmf_pkg::t_col      i_wr_addr,
    input  fnmf_pkg::t_col_pair i_wr_data
);
    import fnmf_pkg::*;

    t_col_pair r_mem [MAX_WIDTH];
    t_col_pair r_rd_a;
    t_col_pair r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> hdl/four_neighbor_mean_filter_top.sv
// ----------------------------------------------------------------------------
// four_neighbor_mean_filter_top
// Cross-shaped 4-neighbor mean over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels arrive one per transfer in row-major order. For every interior pixel
// the block sends floor((up + down + left + right) / 4) tagged with the
// centre's row and column; the result leaves with the transfer of the pixel
// just below the centre, border positions give nothing. The block takes one
// pixel per clock unless its input is stalled: the accepting edge reads the
// two line buffers (one memory of column pairs with two read ports), and
// when stage 1 moves on, that column is written back and the sum is loaded
// into the output register. Input stall rises only when a result is waiting
// in the output register under stall and another result is ready behind it.
// image_width and image_height are clamped to 3..2048; the row and column
// counters wrap at the clamped size. Write configuration only between frames;
// changing size mid-frame can read columns never written.
// ----------------------------------------------------------------------------
module four_neighbor_mean_filter_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [fnmf_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [fnmf_pkg::CFG_BITS-1:0]          i_cfg_data,
    // pixel input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [fnmf_pkg::PIX_BITS-1:0]          i_pixel_value,
    // result output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [fnmf_pkg::PIX_BITS-1:0]          o_mean_value,
    output logic [fnmf_pkg::ROW_BITS-1:0]          o_centre_row,
    output logic [fnmf_pkg::COL_BITS-1:0]          o_centre_col
);
    import fnmf_pkg::*;

    // configuration registers
    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;
    logic [CFG_BITS-1:0] w_eff;
    logic [CFG_BITS-1:0] h_eff;

    // position of the next pixel
    t_row r_row;
    t_col r_col;
    t_row n_row;
    t_col n_col;
    logic [CFG_BITS-1:0] col_inc;
    logic [CFG_BITS-1:0] row_inc;

    // stage 1: pixel waiting for its buffer read
    logic r_s1_valid;
    logic r_s1_hit;
    t_pix r_s1_pix;
    t_col r_s1_col;
    t_row r_s1_row;
    t_pix r_left;

    // output register
    logic r_out_valid;
    t_pix r_out_mean;
    t_row r_out_row;
    t_col r_out_col;

    logic      in_accept;
    logic      hit;
    logic      s1_adv;
    logic      out_busy;
    t_col_pair rd_a;
    t_col_pair rd_b;
    t_col_pair wr_data;
    logic [SUM_BITS-1:0] sum;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes to the supported range
    always_comb begin
        if (r_width < SIZE_MIN) begin
            w_eff = SIZE_MIN;
        end else if (r_width > WIDTH_MAX) begin
            w_eff = WIDTH_MAX;
        end else begin
            w_eff = r_width;
        end
        if (r_height < SIZE_MIN) begin
            h_eff = SIZE_MIN;
        end else if (r_height > HEIGHT_MAX) begin
            h_eff = HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
    end

    // ------------------------------------------------------------- handshake
    assign out_busy   = r_out_valid && i_out_stall;
    // stage 1 moves on unless its result is blocked by a held output
    assign s1_adv     = r_s1_valid && !(r_s1_hit && out_busy);
    assign o_in_stall = r_s1_valid && r_s1_hit && out_busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    // -------------------------------------------------------------- counters
    assign col_inc = {1'b0, r_col} + CFG_BITS'(1);
    assign row_inc = {1'b0, r_row} + CFG_BITS'(1);

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (col_inc >= w_eff) begin
            n_col = '0;
            if (row_inc >= h_eff) begin
                n_row = '0;
            end else begin
                n_row = row_inc[ROW_BITS-1:0];
            end
        end else begin
            n_col = col_inc[COL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // interior centre one row up: rows 1..h-2, columns 1..w-2
    assign hit = (r_row >= ROW_BITS'(2))
              && (row_inc <= h_eff)
              && (r_col != '0)
              && (({1'b0, r_col} + CFG_BITS'(2)) <= w_eff)
              && (r_col != t_col'(MAX_WIDTH - 1));

    // --------------------------------------------------------------- stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
            r_s1_hit   <= hit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pix <= i_pixel_value;
            r_s1_col <= r_col;
            r_s1_row <= r_row - ROW_BITS'(1);
        end
    end

    // previous column of the row one back becomes the left neighbor
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_left <= rd_a.one_back;
        end
    end

    // read own column and the one to the right, write back the shifted pair
    assign wr_data.two_back = rd_a.one_back;
    assign wr_data.one_back = r_s1_pix;

    fnmf_line_buf u_line_buf (
        .i_clk       (i_clk),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (r_col),
        .i_rd_addr_b (r_col + COL_BITS'(1)),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_col),
        .i_wr_data   (wr_data)
    );

    // up + down + left + right
    assign sum = SUM_BITS'(rd_a.two_back) + SUM_BITS'(r_s1_pix)
               + SUM_BITS'(r_left) + SUM_BITS'(rd_b.one_back);

    // --------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_hit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_hit) begin
            r_out_mean <= sum[SUM_BITS-1:2];
            r_out_row  <= r_s1_row;
            r_out_col  <= r_s1_col;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_out_mean;
    assign o_centre_row = r_out_row;
    assign o_centre_col = r_out_col;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-neighbor mean filter.
// ----------------------------------------------------------------------------
// Streams pixels through four_neighbor_mean_filter_top and checks every mean.
// A scoreboard keeps its own line buffers and counters. It works out the
// cross mean, row and column for each pixel transfer and compares them with
// the results in order. Both sides idle at random, the output is held off
// for a long stretch once, and the run covers the clamped lower sizes, a
// frame that fills every buffer column the random runs can reach, a long
// stretch with no gaps on an all-ones height, and short random runs. Some
// of those random runs change the size in the middle of a frame.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fnmf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 600000;
    // stage 1 and the output register drain well within this
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int FILL_WIDTH    = 12;
    localparam int NO_GAP_PIXELS = 150;
    localparam int RANDOM_PIXELS = 300;
    localparam int MAX_REPORTS   = 40;

    // one expected filter result
    typedef struct {
        t_pix mean;
        t_row row;
        t_col col;
    } t_cross_mean;

    // scoreboard: mirrors the line buffers and raster counters, queues means
    class cross_mean_checker;
        logic [CFG_BITS-1:0] width_reg;
        logic [CFG_BITS-1:0] height_reg;
        t_pix                row_two_back [MAX_WIDTH];
        t_pix                row_one_back [MAX_WIDTH];
        int unsigned         row_pos;
        int unsigned         col_pos;
        t_cross_mean         means_due [$];
        int                  errors;
        int                  checked;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
            checked    = 0;
            foreach (row_two_back[i]) begin
                row_two_back[i] = '0;
                row_one_back[i] = '0;
            end
        endfunction

        function void set_size(t_cfg_index idx, logic [CFG_BITS-1:0] value);
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    width_reg = value;
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg = value;
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned clamp_size(logic [CFG_BITS-1:0] value,
                                         logic [CFG_BITS-1:0] hi);
            if (value < SIZE_MIN) return SIZE_MIN;
            if (value > hi) return hi;
            return value;
        endfunction

        function int pending();
            return means_due.size();
        endfunction

        // one accepted pixel: maybe a mean for the centre above it
        function void take_pixel(t_pix px);
            int unsigned         w;
            int unsigned         h;
            int unsigned         r;
            int unsigned         c;
            logic [SUM_BITS-1:0] sum;
            t_cross_mean         due;
            w = clamp_size(width_reg, WIDTH_MAX);
            h = clamp_size(height_reg, HEIGHT_MAX);
            r = row_pos;
            c = col_pos;
            if (r >= 2 && r + 1 <= h && c >= 1 && c + 2 <= w) begin
                sum = SUM_BITS'(row_two_back[c]) + SUM_BITS'(px)
                    + SUM_BITS'(row_two_back[c-1]) + SUM_BITS'(row_one_back[c+1]);
                due.mean = sum[SUM_BITS-1:2];
                due.row  = t_row'(r - 1);
                due.col  = t_col'(c);
                means_due.push_back(due);
            end
            row_two_back[c] = row_one_back[c];
            row_one_back[c] = px;
            // counters wrap with >= so a shrunk size takes effect at once
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'h7FF);
            end else begin
                col_pos = (c + 1) & 32'h7FF;
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch %0d: %s", errors, what);
        endtask

        task check_mean(t_pix mean, t_row row, t_col col);
            t_cross_mean due;
            if (means_due.size() == 0) begin
                report($sformatf("unexpected mean %h at row %0d col %0d", mean, row, col));
                return;
            end
            due = means_due.pop_front();
            if (mean !== due.mean)
                report($sformatf("mean %h, expected %h (row %0d col %0d)",
                                 mean, due.mean, due.row, due.col));
            if (row !== due.row)
                report($sformatf("centre row %0d, expected %0d", row, due.row));
            if (col !== due.col)
                report($sformatf("centre col %0d, expected %0d", col, due.col));
            checked++;
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_we     = 1'b0;
    t_cfg_index          cfg_index  = CFG_IMAGE_WIDTH;
    logic [CFG_BITS-1:0] cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    t_pix                pixel      = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    t_pix                mean_value;
    t_row                centre_row;
    t_col                centre_col;

    // idling switches, cleared for the stretch with no gaps at all
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    // raised by the stimulus to ask the result side for one long hold-off
    bit hold_request   = 1'b0;
    int holds_taken    = 0;
    int pixels_sent    = 0;
    int size_writes    = 0;
    int cycle_count    = 0;

    cross_mean_checker board = new();

    four_neighbor_mean_filter_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pixel_value (pixel),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_mean_value  (mean_value),
        .o_centre_row  (centre_row),
        .o_centre_col  (centre_col)
    );

    always #CLK_HALF clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d means still due",
                     cycle_count, board.pending());
            $display("status: fail");
            $finish;
        end
    end

    // mostly random samples, with the all-zero and all-one extremes mixed in
    function automatic t_pix random_pixel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return t_pix'($urandom);
        endcase
    endfunction

    // mostly small frames; now and then below range, or the top of the small
    // range, or for a height anything 12 bits holds
    function automatic logic [CFG_BITS-1:0] random_size(int unsigned small_hi,
                                                         bit any_size);
        case ($urandom_range(9))
            0: return CFG_BITS'($urandom_range(2));
            1: return any_size ? CFG_BITS'($urandom) : CFG_BITS'(small_hi);
            default: return CFG_BITS'($urandom_range(small_hi, 3));
        endcase
    endfunction

    // register write; starts on a fresh edge so the enable never drops and
    // rises in the same step
    task automatic write_size(t_cfg_index idx, logic [CFG_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_size(idx, value);
        size_writes++;
    endtask

    // one pixel transfer, with random gaps in front of it
    task automatic send_pixel(t_pix value);
        if (sender_idles) begin
            while ($urandom_range(99) < 33) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pixel    <= value;
        // sampled right after the edge, so these are the values the edge saw
        do @(posedge clk); while (in_stall);
        board.take_pixel(value);
        pixels_sent++;
    endtask

    // stop sending, let every due mean come out, then let the pipe settle
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: checks each output transfer, then picks the next stall
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_mean(mean_value, centre_row, centre_col);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_taken++;
            end
            if (hold_left > 0) begin
                // long hold-off so the block backs up and stalls its input
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= receiver_idles && ($urandom_range(99) < 33);
            end
        end
    end

    // pixel side and configuration
    initial begin : stimulus
        t_pix cross_frame [9];
        int   random_sent;
        int   run_length;
        random_sent = 0;
        // up, left and right all ones, down 3: the sum carries into bit 17
        // and the mean is c000
        cross_frame = '{16'h0000, 16'hFFFF, 16'h0000,
                        16'hFFFF, 16'hAAAA, 16'hFFFF,
                        16'h5555, 16'h0003, 16'h5555};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame reached from below range: width 0 and height 2 both
        // clamp up to 3, giving one interior pixel per frame
        write_size(CFG_IMAGE_WIDTH, '0);
        write_size(CFG_IMAGE_HEIGHT, CFG_BITS'(2));
        repeat (9) send_pixel('1);
        foreach (cross_frame[i]) send_pixel(cross_frame[i]);
        wait_until_drained();

        // one frame at the widest random width: fills every buffer column the
        // random runs can reach, so later size changes never read an
        // unwritten entry
        write_size(CFG_IMAGE_WIDTH, CFG_BITS'(FILL_WIDTH));
        write_size(CFG_IMAGE_HEIGHT, SIZE_MIN);
        for (int i = 0; i < 3 * FILL_WIDTH; i++) begin
            // the sender keeps offering through the hold-off in the result row
            if (i == 2 * FILL_WIDTH + 1) hold_request = 1'b1;
            send_pixel(random_pixel());
        end
        wait_until_drained();

        // long stretch with no idling on either side; all-ones height clamps
        // to the tallest frame
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        write_size(CFG_IMAGE_WIDTH, SIZE_MIN);
        write_size(CFG_IMAGE_HEIGHT, '1);
        repeat (NO_GAP_PIXELS) send_pixel(random_pixel());
        wait_until_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // short runs of random length, mostly on small frames; runs do not
        // line up with frames, so sizes also change in mid-frame and the
        // counters wrap at once when left beyond the new size
        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(3) != 0) begin
                if ($urandom_range(1) == 1)
                    write_size(CFG_IMAGE_WIDTH, random_size(FILL_WIDTH, 1'b0));
                if ($urandom_range(1) == 1)
                    write_size(CFG_IMAGE_HEIGHT, random_size(7, 1'b1));
            end
            run_length = $urandom_range(60, 1);
            repeat (run_length) send_pixel(random_pixel());
            random_sent += run_length;
            // a run without a size write is just a pause until all means are in
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d pixel transfers and %0d means checked", pixels_sent,
                 board.checked);
        $display("over %0d size writes, %0d long output hold-offs, %0d mismatches",
                 size_writes, holds_taken, board.errors);
        if (board.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
